[src/ipaf_pkg.sv]
// Shared types, function codes and the prefix-to-mask helper for the
// IPv4 prefix access filter. No dependencies.
`default_nettype none

package ipaf_pkg;

  localparam int unsigned AddrBits = 32;
  localparam int unsigned LenBits  = 6;

  localparam logic [AddrBits-1:0] AllOnes = 32'hFFFF_FFFF;

  // Item function codes carried in tuser
  typedef enum logic [1:0] {
    FuncClear    = 2'd0,
    FuncAddAllow = 2'd1,
    FuncAddDeny  = 2'd2,
    FuncCheck    = 2'd3
  } func_e;

  // One stored rule: compare mask over the rule address
  typedef struct packed {
    logic [AddrBits-1:0] mask;
    logic [AddrBits-1:0] addr;
  } rule_t;

  // Mask of len leading ones, saturating at the address width
  function automatic logic [AddrBits-1:0] prefix_mask(logic [LenBits-1:0] len);
    logic [LenBits-1:0] n;
    logic [AddrBits-1:0] m;
    begin
      n = (len > LenBits'(AddrBits)) ? LenBits'(AddrBits) : len;
      if (n == '0) begin
        m = '0;
      end else begin
        m = AllOnes << (LenBits'(AddrBits) - n);
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

[src/ipaf_rule_mem.sv]
// Rule store for both lists: one write port, one registered read port.
// Depends on ipaf_pkg for the rule entry type.
`default_nettype none

module ipaf_rule_mem
  import ipaf_pkg::*;
#(
  parameter int unsigned AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire rule_t            wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      rule_t            rd_data_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  rule_t mem_q [Depth];
  rule_t rd_data_q;

  // Write a new rule
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[src/ipaf_match.sv]
// Shared prefix compare unit: tests one address against one rule.
// Depends on ipaf_pkg for the rule entry type.
`default_nettype none

module ipaf_match
  import ipaf_pkg::*;
(
  input  wire logic [AddrBits-1:0] ip_i,
  input  wire rule_t               rule_i,
  output      logic                hit_o
);

  // Compare only the bits under the mask
  assign hit_o = ((ip_i & rule_i.mask) == (rule_i.addr & rule_i.mask));

endmodule

`default_nettype wire

[src/ip_prefix_access_filter.sv]
// IPv4 prefix access filter: accept/reject rule lists with a scan sequencer.
// Depends on ipaf_pkg, ipaf_rule_mem and ipaf_match.
//
// Usage:
//   Input items arrive on the s_axis group. tuser selects the function:
//   clear both lists, add an accept rule, add a reject rule, or check an
//   address. tdata carries the address and the prefix length of a rule.
//   Every item gives exactly one result item on the m_axis group:
//   permitted (checks) and status (1 when an add hit a full list).
//   Clear and add items finish in the cycle they are accepted; the result
//   is registered and visible in the next cycle. A check walks the accept
//   list, then the reject list, one rule per cycle through the read port
//   of the rule memory; a match ends the walk sooner. The verdict then
//   waits in the finish state until the output register is free.
//   The input is not ready while a check is in progress, nor while a result
//   waits in the output register and the receiver holds tready low.
//   Reset empties both lists and the output register; rule contents are
//   not cleared, only the counts.
`default_nettype none

module ip_prefix_access_filter
  import ipaf_pkg::*;
#(
  parameter int unsigned RULES_PER_LIST = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [31:0] address, [37:32] prefix_len, [39:38] zero
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] func
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o   // [0] permitted, [1] status, [7:2] zero
);

  localparam int unsigned IdxW  = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
  localparam int unsigned CntW  = $clog2(RULES_PER_LIST + 1);
  localparam int unsigned MemAW = IdxW + 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(RULES_PER_LIST);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]     allow_cnt_q, allow_cnt_d;
  logic [CntW-1:0]     deny_cnt_q, deny_cnt_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                list_q, list_d;
  logic                pend_q, pend_d;
  logic                perm_q, perm_d;
  logic [AddrBits-1:0] ip_q, ip_d;

  logic out_vld_q, out_vld_d;
  logic out_perm_q, out_perm_d;
  logic out_stat_q, out_stat_d;

  logic                in_acc;
  logic                out_free;
  func_e               func;
  logic [AddrBits-1:0] in_addr;
  logic [LenBits-1:0]  in_len;

  logic             wr_en;
  logic [MemAW-1:0] wr_addr;
  rule_t            wr_rule;
  logic             rd_en;
  logic [MemAW-1:0] rd_addr;
  rule_t            rd_rule;
  logic             hit;
  logic [CntW-1:0]  cur_cnt;
  logic             issue;

  assign func    = func_e'(s_axis_tuser_i);
  assign in_addr = s_axis_tdata_i[AddrBits-1:0];
  assign in_len  = s_axis_tdata_i[AddrBits+LenBits-1:AddrBits];

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign cur_cnt = list_q ? deny_cnt_q : allow_cnt_q;
  assign issue   = (state_q == StScan) && (idx_q < cur_cnt);
  assign rd_en   = issue;
  assign rd_addr = {list_q, idx_q[IdxW-1:0]};

  assign wr_rule.addr = in_addr;
  assign wr_rule.mask = prefix_mask(in_len);

  ipaf_rule_mem #(
    .AddrW(MemAW)
  ) u_rule_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_rule),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_rule)
  );

  ipaf_match u_match (
    .ip_i  (ip_q),
    .rule_i(rd_rule),
    .hit_o (hit)
  );

  // Sequencer: decode items, walk the lists, hand results to the output
  always_comb begin
    state_d     = state_q;
    allow_cnt_d = allow_cnt_q;
    deny_cnt_d  = deny_cnt_q;
    idx_d       = idx_q;
    list_d      = list_q;
    pend_d      = pend_q;
    perm_d      = perm_q;
    ip_d        = ip_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_perm_d  = out_perm_q;
    out_stat_d  = out_stat_q;
    wr_en       = 1'b0;
    wr_addr     = {1'b0, allow_cnt_q[IdxW-1:0]};

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (func)
            FuncClear: begin
              allow_cnt_d = '0;
              deny_cnt_d  = '0;
              out_vld_d   = 1'b1;
              out_perm_d  = 1'b0;
              out_stat_d  = 1'b0;
            end
            FuncAddAllow: begin
              out_vld_d  = 1'b1;
              out_perm_d = 1'b0;
              out_stat_d = (allow_cnt_q == FullCnt);
              if (allow_cnt_q != FullCnt) begin
                wr_en       = 1'b1;
                wr_addr     = {1'b0, allow_cnt_q[IdxW-1:0]};
                allow_cnt_d = allow_cnt_q + CntW'(1);
              end
            end
            FuncAddDeny: begin
              out_vld_d  = 1'b1;
              out_perm_d = 1'b0;
              out_stat_d = (deny_cnt_q == FullCnt);
              if (deny_cnt_q != FullCnt) begin
                wr_en      = 1'b1;
                wr_addr    = {1'b1, deny_cnt_q[IdxW-1:0]};
                deny_cnt_d = deny_cnt_q + CntW'(1);
              end
            end
            FuncCheck: begin
              ip_d    = in_addr;
              list_d  = 1'b0;
              idx_d   = '0;
              pend_d  = 1'b0;
              state_d = StScan;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StScan: begin
        pend_d = issue;
        idx_d  = idx_q + CntW'(issue);
        if (pend_q && hit) begin
          // Accept list match permits, reject list match denies
          perm_d  = !list_q;
          pend_d  = 1'b0;
          state_d = StFinish;
        end else if (!issue && !pend_q) begin
          if (!list_q) begin
            list_d = 1'b1;
            idx_d  = '0;
          end else begin
            perm_d  = 1'b1;
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        // Hold the verdict until the output register is free
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_perm_d = perm_q;
          out_stat_d = 1'b0;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      allow_cnt_q <= '0;
      deny_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      allow_cnt_q <= allow_cnt_d;
      deny_cnt_q  <= deny_cnt_d;
      pend_q      <= pend_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    list_q     <= list_d;
    perm_q     <= perm_d;
    ip_q       <= ip_d;
    out_perm_q <= out_perm_d;
    out_stat_q <= out_stat_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_stat_q, out_perm_q};

endmodule

`default_nettype wire
